// ===== design/fes_pkg.sv =====
`timescale 1ns / 1ps
// fes_pkg: item types, character codes and shared-unit control types
// for the fraction expression summer; no dependencies

package fes_pkg;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [31:0] OUT_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] numerator;
		logic [30:0]        denominator;
		logic               overflow;
	} out_item_t;

	typedef enum logic [1:0] {
		ALU_GCD,
		ALU_DIV,
		ALU_MUL
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_cmd_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} alu_sts_t;

endpackage

// ===== design/fes_alu.sv =====
`timescale 1ns / 1ps
// fes_alu: shared iterative unit, binary gcd, restoring divide and
// range-checked shift-add multiply, one step per cycle; uses fes_pkg

module fes_alu #(
	parameter int UW        = 64,
	parameter int ACC_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fes_pkg::alu_cmd_t   cmd,
	input  logic [UW-1:0]       opa,
	input  logic [UW-1:0]       opb,
	output fes_pkg::alu_sts_t   sts,
	output logic [UW-1:0]       res
);
	import fes_pkg::*;

	localparam int KW  = $clog2(UW) + 1;
	localparam int CNW = $clog2(UW + 1);
	localparam logic [UW:0] ACC_MAX = (UW+1)'((65'd1 << (ACC_WIDTH - 1)) - 65'd1);

	typedef enum logic [2:0] {
		A_IDLE,
		A_GCD,
		A_SHL,
		A_DIV,
		A_MUL
	} astate_t;

	astate_t         state_q;
	logic [UW-1:0]   x_q;
	logic [UW-1:0]   y_q;
	logic [UW:0]     acc_q;
	logic [KW-1:0]   k_q;
	logic [CNW-1:0]  cnt_q;
	logic            ovf_q;
	logic            done_q;
	logic [UW-1:0]   res_q;

	logic [UW:0]     rem_sh;
	logic            rem_ge;
	logic [UW:0]     rem_sub;
	logic [UW:0]     mul_add;
	logic            mul_big;

	always_comb begin
		rem_sh  = {acc_q[UW-1:0], x_q[UW-1]};
		rem_ge  = rem_sh >= {1'b0, y_q};
		rem_sub = rem_sh - {1'b0, y_q};
		mul_add = {acc_q[UW-1:0], 1'b0} + (y_q[UW-1] ? {1'b0, x_q} : {(UW+1){1'b0}});
		mul_big = mul_add > ACC_MAX;
	end

	assign sts.done = done_q;
	assign sts.ovf  = ovf_q;
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			acc_q   <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (cmd.start) begin
						x_q   <= opa;
						y_q   <= opb;
						acc_q <= '0;
						k_q   <= '0;
						ovf_q <= 1'b0;
						cnt_q <= CNW'(UW);
						case (cmd.op)
							ALU_GCD: state_q <= A_GCD;
							ALU_DIV: state_q <= A_DIV;
							ALU_MUL: state_q <= A_MUL;
							default: state_q <= A_IDLE;
						endcase
					end
				end
				A_GCD: begin
					if (x_q == '0) begin
						x_q     <= y_q;
						state_q <= A_SHL;
					end else if (y_q == '0) begin
						state_q <= A_SHL;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + KW'(1);
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q >= y_q) begin
						x_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
				A_SHL: begin
					// restore the common power of two
					if (k_q == '0) begin
						res_q   <= x_q;
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end else begin
						x_q <= x_q << 1;
						k_q <= k_q - KW'(1);
					end
				end
				A_DIV: begin
					acc_q <= rem_ge ? rem_sub : rem_sh;
					x_q   <= {x_q[UW-2:0], rem_ge};
					cnt_q <= cnt_q - CNW'(1);
					if (cnt_q == CNW'(1)) begin
						res_q   <= {x_q[UW-2:0], rem_ge};
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end
				end
				A_MUL: begin
					// partial sums only grow, so any one above range flags the product
					acc_q <= mul_add;
					y_q   <= y_q << 1;
					ovf_q <= ovf_q | mul_big;
					cnt_q <= cnt_q - CNW'(1);
					if (cnt_q == CNW'(1)) begin
						res_q   <= mul_add[UW-1:0];
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

endmodule

// ===== design/fraction_expression_summer_core.sv =====
`timescale 1ns / 1ps
// a digit or '/' is taken in S_IDLE; '+', '-' or the final character closes a
// fraction through the shared unit: a gcd, two divides and three multiplies, with
// sequencer states between them; the final character adds a gcd and two divides
// before the result; one item at a time, no item taken while the unit works;
// result waits in an output register
// arst_n clears the running sum to 0/1, all flags, and the output valid

module fraction_expression_summer_core #(
	parameter int NUMBER_WIDTH = 32,
	parameter int ACC_WIDTH    = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  fes_pkg::in_item_t   char_item,
	output logic                sum_valid,
	input  logic                sum_ready,
	output fes_pkg::out_item_t  sum_item
);
	import fes_pkg::*;

	localparam int NW = NUMBER_WIDTH;
	localparam int UW = (ACC_WIDTH > NUMBER_WIDTH) ? ACC_WIDTH : NUMBER_WIDTH;
	localparam int CW = (UW > 32) ? UW : 32;
	localparam logic [NW+3:0] NUM_MAX = (NW+4)'((65'd1 << (NW - 1)) - 65'd1);
	localparam logic [UW:0]   ACC_MAX = (UW+1)'((65'd1 << (ACC_WIDTH - 1)) - 65'd1);
	localparam logic [CW-1:0] OUT_MAX_C = CW'(OUT_MAX);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CL0,
		S_G,
		S_DD,
		S_DQ,
		S_ML,
		S_MA,
		S_MB,
		S_END,
		S_FG,
		S_FN,
		S_FD,
		S_OUT
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   cur_q;
	logic [NW-1:0]   pend_mag_q;
	logic            pend_neg_q;
	logic            neg_next_q;
	logic            at_start_q;
	logic            ovf_q;
	logic            last_q;
	logic [UW-1:0]   sum_mag_q;
	logic            sum_neg_q;
	logic [UW-1:0]   sum_den_q;
	logic [UW-1:0]   g_q;
	logic [UW-1:0]   dg_q;
	logic [UW-1:0]   qg_q;
	logic [UW-1:0]   l_q;
	logic [UW-1:0]   a_q;
	logic            alu_go_q;
	alu_op_t         alu_op_q;
	logic [UW-1:0]   opa_q;
	logic [UW-1:0]   opb_q;
	logic            sum_valid_q;
	out_item_t       sum_item_q;

	alu_cmd_t        alu_cmd;
	alu_sts_t        alu_sts;
	logic [UW-1:0]   alu_res;

	logic            accept;
	logic            alu_issue;
	logic            out_load;
	logic            is_digit;
	logic            is_slash;
	logic            is_op;
	logic [NW+3:0]   dig_prod;
	logic            dig_sat;
	logic            pend_is_neg;
	logic [UW:0]     ab_sum;
	logic            ab_ge;
	logic            out_bad;

	fes_alu #(
		.UW        (UW),
		.ACC_WIDTH (ACC_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.opa    (opa_q),
		.opb    (opb_q),
		.sts    (alu_sts),
		.res    (alu_res)
	);

	assign char_ready = (state_q == S_IDLE);
	assign accept     = char_valid && char_ready;
	assign sum_valid  = sum_valid_q;
	assign sum_item   = sum_item_q;
	assign out_load   = (state_q == S_OUT) && (!sum_valid_q || sum_ready);

	always_comb begin
		alu_cmd.start = alu_go_q;
		alu_cmd.op    = alu_op_q;
		is_digit = char_item.char_code inside {[CH_0:CH_9]};
		is_slash = char_item.char_code == CH_SLASH;
		is_op    = (char_item.char_code == CH_PLUS) || (char_item.char_code == CH_MINUS);
		dig_prod = ((NW+4)'(cur_q) << 3) + ((NW+4)'(cur_q) << 1)
			+ (NW+4)'(char_item.char_code[3:0]);
		dig_sat  = dig_prod > NUM_MAX;
		pend_is_neg = pend_neg_q && (pend_mag_q != '0);
		ab_sum   = {1'b0, a_q} + {1'b0, alu_res};
		ab_ge    = a_q >= alu_res;
		out_bad  = ovf_q || (CW'(a_q) > OUT_MAX_C) || (CW'(l_q) > OUT_MAX_C);
	end

	// one-cycle start pulse whenever the sequencer hands the unit a new operation
	always_comb begin
		alu_issue = 1'b0;
		case (state_q)
			S_IDLE: alu_issue = accept && is_op && at_start_q && char_item.last;
			S_CL0: alu_issue = cur_q != '0;
			S_G, S_DD, S_DQ, S_FG, S_FN: alu_issue = alu_sts.done;
			S_ML, S_MA: alu_issue = alu_sts.done && !alu_sts.ovf;
			S_END: alu_issue = last_q;
			default: alu_issue = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			pend_mag_q  <= '0;
			pend_neg_q  <= 1'b0;
			neg_next_q  <= 1'b0;
			at_start_q  <= 1'b1;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			sum_mag_q   <= '0;
			sum_neg_q   <= 1'b0;
			sum_den_q   <= UW'(1);
			g_q         <= '0;
			dg_q        <= '0;
			qg_q        <= '0;
			l_q         <= '0;
			a_q         <= '0;
			alu_go_q    <= 1'b0;
			alu_op_q    <= ALU_GCD;
			opa_q       <= '0;
			opb_q       <= '0;
			sum_valid_q <= 1'b0;
			sum_item_q  <= '0;
		end else begin
			alu_go_q <= alu_issue;
			if (out_load) begin
				sum_valid_q <= 1'b1;
			end else if (sum_valid_q && sum_ready) begin
				sum_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= char_item.last;
						if (is_digit) begin
							cur_q      <= dig_sat ? NW'(NUM_MAX) : NW'(dig_prod);
							ovf_q      <= ovf_q | dig_sat;
							at_start_q <= 1'b0;
							if (char_item.last) begin
								state_q <= S_CL0;
							end
						end else if (is_slash) begin
							pend_mag_q <= cur_q;
							pend_neg_q <= neg_next_q;
							neg_next_q <= 1'b0;
							cur_q      <= '0;
							at_start_q <= 1'b0;
							if (char_item.last) begin
								state_q <= S_CL0;
							end
						end else if (is_op) begin
							neg_next_q <= char_item.char_code == CH_MINUS;
							if (!at_start_q) begin
								// cur_q holds the denominator until the close ends
								state_q <= S_CL0;
							end else begin
								cur_q <= '0;
								if (char_item.last) begin
									alu_op_q <= ALU_GCD;
									opa_q    <= sum_mag_q;
									opb_q    <= sum_den_q;
									state_q  <= S_FG;
								end
							end
						end else begin
							cur_q <= '0;
							if (char_item.last) begin
								state_q <= S_CL0;
							end
						end
					end
				end
				S_CL0: begin
					if (cur_q == '0) begin
						ovf_q   <= 1'b1;
						state_q <= S_END;
					end else begin
						alu_op_q <= ALU_GCD;
						opa_q    <= sum_den_q;
						opb_q    <= UW'(cur_q);
						state_q  <= S_G;
					end
				end
				S_G: begin
					if (alu_sts.done) begin
						g_q      <= alu_res;
						alu_op_q <= ALU_DIV;
						opa_q    <= sum_den_q;
						opb_q    <= alu_res;
						state_q  <= S_DD;
					end
				end
				S_DD: begin
					if (alu_sts.done) begin
						dg_q     <= alu_res;
						alu_op_q <= ALU_DIV;
						opa_q    <= UW'(cur_q);
						opb_q    <= g_q;
						state_q  <= S_DQ;
					end
				end
				S_DQ: begin
					if (alu_sts.done) begin
						qg_q     <= alu_res;
						alu_op_q <= ALU_MUL;
						opa_q    <= dg_q;
						opb_q    <= UW'(cur_q);
						state_q  <= S_ML;
					end
				end
				S_ML: begin
					if (alu_sts.done) begin
						if (alu_sts.ovf) begin
							ovf_q   <= 1'b1;
							state_q <= S_END;
						end else begin
							l_q      <= alu_res;
							alu_op_q <= ALU_MUL;
							opa_q    <= sum_mag_q;
							opb_q    <= qg_q;
							state_q  <= S_MA;
						end
					end
				end
				S_MA: begin
					if (alu_sts.done) begin
						if (alu_sts.ovf) begin
							ovf_q   <= 1'b1;
							state_q <= S_END;
						end else begin
							a_q      <= alu_res;
							alu_op_q <= ALU_MUL;
							opa_q    <= UW'(pend_mag_q);
							opb_q    <= dg_q;
							state_q  <= S_MB;
						end
					end
				end
				S_MB: begin
					if (alu_sts.done) begin
						state_q <= S_END;
						if (alu_sts.ovf) begin
							ovf_q <= 1'b1;
						end else if (sum_neg_q == pend_is_neg) begin
							if (ab_sum > ACC_MAX) begin
								ovf_q <= 1'b1;
							end else begin
								sum_mag_q <= ab_sum[UW-1:0];
								sum_neg_q <= sum_neg_q && (ab_sum != '0);
								sum_den_q <= l_q;
							end
						end else if (ab_ge) begin
							sum_mag_q <= a_q - alu_res;
							sum_neg_q <= sum_neg_q && (a_q != alu_res);
							sum_den_q <= l_q;
						end else begin
							sum_mag_q <= alu_res - a_q;
							sum_neg_q <= pend_is_neg;
							sum_den_q <= l_q;
						end
					end
				end
				S_END: begin
					cur_q      <= '0;
					pend_mag_q <= '0;
					pend_neg_q <= 1'b0;
					at_start_q <= 1'b1;
					if (last_q) begin
						alu_op_q <= ALU_GCD;
						opa_q    <= sum_mag_q;
						opb_q    <= sum_den_q;
						state_q  <= S_FG;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FG: begin
					if (alu_sts.done) begin
						g_q      <= alu_res;
						alu_op_q <= ALU_DIV;
						opa_q    <= sum_mag_q;
						opb_q    <= alu_res;
						state_q  <= S_FN;
					end
				end
				S_FN: begin
					if (alu_sts.done) begin
						a_q      <= alu_res;
						alu_op_q <= ALU_DIV;
						opa_q    <= sum_den_q;
						opb_q    <= g_q;
						state_q  <= S_FD;
					end
				end
				S_FD: begin
					if (alu_sts.done) begin
						l_q     <= alu_res;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						if (out_bad) begin
							sum_item_q <= '{numerator: 32'sd0, denominator: 31'd1,
								overflow: 1'b1};
						end else begin
							sum_item_q.numerator   <= sum_neg_q ? -$signed(32'(a_q))
								: $signed(32'(a_q));
							sum_item_q.denominator <= 31'(l_q);
							sum_item_q.overflow    <= 1'b0;
						end
						// expression done, back to the reset state
						cur_q      <= '0;
						pend_mag_q <= '0;
						pend_neg_q <= 1'b0;
						neg_next_q <= 1'b0;
						at_start_q <= 1'b1;
						ovf_q      <= 1'b0;
						last_q     <= 1'b0;
						sum_mag_q  <= '0;
						sum_neg_q  <= 1'b0;
						sum_den_q  <= UW'(1);
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |-> sum_item.denominator != 31'd0)
		else $error("result denominator is zero");

	a_ovf_form: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_item.overflow |->
			sum_item.numerator == 32'sd0 && sum_item.denominator == 31'd1)
		else $error("overflow result not 0/1");

	a_sum_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> sum_den_q != '0)
		else $error("running denominator is zero");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		alu_sts.done |-> state_q != S_IDLE && state_q != S_OUT)
		else $error("unit finished with no operation pending");
`endif

endmodule
